FILE: rtl/mctp_packet_reassembly_tracker_top_macros.svh
// Assertion macros used by the reassembly tracker engine.
`ifndef MCTP_PACKET_REASSEMBLY_TRACKER_TOP_MACROS_SVH
`define MCTP_PACKET_REASSEMBLY_TRACKER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// Property check on i_clk, masked while i_rst_n is low.
`define MPRT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Condition that must never be true on a clock edge.
`define MPRT_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);
`else
`define MPRT_ASSERT(label, prop, msg)
`define MPRT_ASSERT_NEVER(label, cond, msg)
`endif

`endif

FILE: rtl/mprt_pkg.sv
// Types, codes and defaults for the MCTP reassembly tracker.
package mprt_pkg;

    // Parameter defaults
    localparam int NUM_TAGS_DEF    = 8;
    localparam int MAX_PAYLOAD_DEF = 64;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_OWN_EID   = 2'd0;
    localparam logic [1:0] REG_CTRL_EN   = 2'd1;
    localparam logic [1:0] REG_PLDM_EN   = 2'd2;

    // Verdict codes
    localparam logic [3:0] V_NOT_OURS  = 4'd0;
    localparam logic [3:0] V_BAD_SEQ   = 4'd1;
    localparam logic [3:0] V_NO_CTX    = 4'd2;
    localparam logic [3:0] V_VER_DROP  = 4'd3;
    localparam logic [3:0] V_MISMATCH  = 4'd4;
    localparam logic [3:0] V_SINGLE    = 4'd5;
    localparam logic [3:0] V_STARTED   = 4'd6;
    localparam logic [3:0] V_APPENDED  = 4'd7;
    localparam logic [3:0] V_ASSEMBLED = 4'd8;
    localparam logic [3:0] V_LEN_ABORT = 4'd9;

    // Consumer codes
    localparam logic [1:0] CONS_NONE = 2'd0;
    localparam logic [1:0] CONS_CTRL = 2'd1;
    localparam logic [1:0] CONS_PLDM = 2'd2;

    // Special endpoint IDs
    localparam logic [7:0] EID_NULL      = 8'h00;
    localparam logic [7:0] EID_BROADCAST = 8'hFF;

    // Message types
    localparam logic [6:0] MT_CONTROL = 7'd0;
    localparam logic [6:0] MT_PLDM    = 7'd1;

    // Configuration register contents
    typedef struct packed {
        logic [7:0] own_eid;
        logic       control_enable;
        logic       pldm_enable;
    } t_cfg;

    // Per-tag context kept in RAM (active flag lives in flops)
    typedef struct packed {
        logic        owner;
        logic [3:0]  version;
        logic [1:0]  next_seq;
        logic [6:0]  first_len;
        logic [15:0] total_len;
        logic [6:0]  msg_type;
    } t_ctx;

    // Header beat
    typedef struct packed {
        logic [7:0] dest_eid;
        logic [7:0] source_eid;
        logic       start_mark;
        logic       end_mark;
        logic [1:0] packet_seq;
        logic       owner_bit;
        logic [2:0] msg_tag;
        logic [3:0] hdr_version;
        logic [6:0] payload_len;
        logic [6:0] msg_type;
    } t_pkt;

    // Result beat
    typedef struct packed {
        logic [3:0]  verdict;
        logic [1:0]  consumer;
        logic [15:0] delivered_len;
        logic [7:0]  receiver_out;
        logic [7:0]  sender_out;
        logic [2:0]  tag_out;
        logic        owner_out;
    } t_res;

endpackage

FILE: rtl/mprt_ifs.sv
// Valid/ready channel interfaces for header and result beats.
interface mprt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] dest_eid;
    logic [7:0] source_eid;
    logic       start_mark;
    logic       end_mark;
    logic [1:0] packet_seq;
    logic       owner_bit;
    logic [2:0] msg_tag;
    logic [3:0] hdr_version;
    logic [6:0] payload_len;
    logic [6:0] msg_type;

    modport source (
        output valid, dest_eid, source_eid, start_mark, end_mark, packet_seq,
               owner_bit, msg_tag, hdr_version, payload_len, msg_type,
        input  ready
    );
    modport sink (
        input  valid, dest_eid, source_eid, start_mark, end_mark, packet_seq,
               owner_bit, msg_tag, hdr_version, payload_len, msg_type,
        output ready
    );
endinterface

interface mprt_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  verdict;
    logic [1:0]  consumer;
    logic [15:0] delivered_len;
    logic [7:0]  receiver_out;
    logic [7:0]  sender_out;
    logic [2:0]  tag_out;
    logic        owner_out;

    modport source (
        output valid, verdict, consumer, delivered_len, receiver_out, sender_out,
               tag_out, owner_out,
        input  ready
    );
    modport sink (
        input  valid, verdict, consumer, delivered_len, receiver_out, sender_out,
               tag_out, owner_out,
        output ready
    );
endinterface

FILE: rtl/mctp_packet_reassembly_tracker_top.sv
// Top level of the MCTP packet reassembly tracker.
//
//  channel   dir  handshake                      beat
//  i_pkt     in   valid/ready                    one received packet header
//  o_res     out  valid/ready                    one verdict per header
//  apb       in   psel/penable/pwrite, pready=1  own_eid, control/pldm enables
//
// A header taken is held in the decode stage until its result moves to the result register.
// Up to one header per cycle while the result side keeps ready high; the block
// holds at most two headers, one in the decode stage and one in the result register.
// Back-to-back headers on the same tag use a forward path around the context RAM.
// Reset clears the context valid flops at once; no clearing pass.
// i_pkt.ready drops while the decode stage is full and its result cannot move.
module mctp_packet_reassembly_tracker_top
    import mprt_pkg::*;
#(
    parameter int NUM_TAGS    = NUM_TAGS_DEF,
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    mprt_in_if.sink     i_pkt,
    mprt_out_if.source  o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg cfg;

    mprt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    mprt_engine #(
        .NUM_TAGS    (NUM_TAGS),
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_pkt   (i_pkt),
        .o_res   (o_res)
    );

endmodule

FILE: rtl/mprt_cfg.sv
// APB configuration registers: own EID and consumer enables.
module mprt_cfg
    import mprt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            case (paddr[3:2])
                REG_OWN_EID: r_cfg.own_eid        <= pwdata[7:0];
                REG_CTRL_EN: r_cfg.control_enable <= pwdata[0];
                REG_PLDM_EN: r_cfg.pldm_enable    <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (paddr[3:2])
            REG_OWN_EID: prdata = {24'd0, r_cfg.own_eid};
            REG_CTRL_EN: prdata = {31'd0, r_cfg.control_enable};
            REG_PLDM_EN: prdata = {31'd0, r_cfg.pldm_enable};
            default:     prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/mprt_ctx_ram.sv
// Per-tag context RAM: one write port, one registered read port.
module mprt_ctx_ram
    import mprt_pkg::*;
#(
    parameter int DEPTH = NUM_TAGS_DEF,
    parameter int IDX_W = 3
)(
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  t_ctx             i_wr_data,
    input  logic [IDX_W-1:0] i_rd_addr,
    output t_ctx             o_rd_data
);

    t_ctx mem [DEPTH];
    t_ctx r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read-before-write; caller forwards same-entry writes
    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/mprt_engine.sv
// Header decode stage: context read-modify-write and result register.
`include "mctp_packet_reassembly_tracker_top_macros.svh"
module mprt_engine
    import mprt_pkg::*;
#(
    parameter int NUM_TAGS    = NUM_TAGS_DEF,
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
)(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cfg   i_cfg,
    mprt_in_if.sink    i_pkt,
    mprt_out_if.source o_res
);

    localparam int IDX_W = (NUM_TAGS > 1) ? $clog2(NUM_TAGS) : 1;

    // Stage 1 (item waiting on its context read) and output register
    logic             r_s1_vld;
    t_pkt             r_s1;
    logic             r_out_vld;
    t_res             r_out;
    logic [NUM_TAGS-1:0] r_vld;
    logic             r_fwd;
    t_ctx             r_fwd_data;

    t_pkt             in_pkt;
    logic             in_tag_ok;
    logic [IDX_W-1:0] in_idx;
    logic             s1_fire;
    logic             in_fire;
    logic [IDX_W-1:0] rd_addr;
    t_ctx             rd_data;
    t_ctx             ctx;

    logic             s1_tag_ok;
    logic [IDX_W-1:0] s1_idx;
    logic [6:0]       plen;
    logic             dest_ok;
    logic             active;
    logic [16:0]      sum_raw;
    logic [15:0]      sum_sat;
    logic             deliver;
    logic             wr_en;
    logic             set_vld;
    logic             clr_vld;
    t_ctx             wr_data;
    t_res             n_out;

    // Gather header beat
    assign in_pkt = '{
        dest_eid:    i_pkt.dest_eid,
        source_eid:  i_pkt.source_eid,
        start_mark:  i_pkt.start_mark,
        end_mark:    i_pkt.end_mark,
        packet_seq:  i_pkt.packet_seq,
        owner_bit:   i_pkt.owner_bit,
        msg_tag:     i_pkt.msg_tag,
        hdr_version: i_pkt.hdr_version,
        payload_len: i_pkt.payload_len,
        msg_type:    i_pkt.msg_type
    };

    // Handshake
    assign s1_fire     = r_s1_vld && (!r_out_vld || o_res.ready);
    assign i_pkt.ready = !r_s1_vld || s1_fire;
    assign in_fire     = i_pkt.valid && i_pkt.ready;

    // Context index, tags beyond the table map to entry 0
    assign in_tag_ok = {1'b0, in_pkt.msg_tag} < 4'(NUM_TAGS);
    assign in_idx    = in_tag_ok ? in_pkt.msg_tag[IDX_W-1:0] : '0;
    assign s1_tag_ok = {1'b0, r_s1.msg_tag} < 4'(NUM_TAGS);
    assign s1_idx    = s1_tag_ok ? r_s1.msg_tag[IDX_W-1:0] : '0;

    // A held item re-reads its own entry each cycle
    assign rd_addr = (r_s1_vld && !s1_fire) ? s1_idx : in_idx;

    mprt_ctx_ram #(
        .DEPTH (NUM_TAGS),
        .IDX_W (IDX_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (s1_idx),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Forward a write that hit the entry read in the same cycle
    assign ctx    = r_fwd ? r_fwd_data : rd_data;
    assign active = s1_tag_ok && r_vld[s1_idx];

    // Clamp length, destination filter, running total
    assign plen = ({1'b0, r_s1.payload_len} > 8'(MAX_PAYLOAD)) ?
                  7'(MAX_PAYLOAD) : r_s1.payload_len;
    assign dest_ok = (r_s1.dest_eid == i_cfg.own_eid) ||
                     (r_s1.dest_eid == EID_BROADCAST) ||
                     (r_s1.dest_eid == EID_NULL);
    assign sum_raw = {1'b0, ctx.total_len} + {10'd0, plen};
    assign sum_sat = sum_raw[16] ? 16'hFFFF : sum_raw[15:0];

    function automatic logic [1:0] pick_consumer(input logic [6:0] mtype, input t_cfg cfg);
        logic [1:0] c;
        c = CONS_NONE;
        if (mtype == MT_CONTROL && cfg.control_enable) c = CONS_CTRL;
        else if (mtype == MT_PLDM && cfg.pldm_enable) c = CONS_PLDM;
        return c;
    endfunction

    // Verdict and context update
    always_comb begin
        n_out         = '0;
        n_out.tag_out = r_s1.msg_tag;
        deliver       = 1'b0;
        wr_en         = 1'b0;
        set_vld       = 1'b0;
        clr_vld       = 1'b0;
        wr_data       = ctx;
        if (!dest_ok) begin
            n_out.verdict = V_NOT_OURS;
        end else if (r_s1.start_mark) begin
            if (r_s1.packet_seq != 2'd0) begin
                n_out.verdict = V_BAD_SEQ;
            end else if (r_s1.end_mark) begin
                n_out.verdict       = V_SINGLE;
                deliver             = 1'b1;
                n_out.consumer      = pick_consumer(r_s1.msg_type, i_cfg);
                n_out.delivered_len = {9'd0, plen};
            end else if (!s1_tag_ok) begin
                n_out.verdict = V_NO_CTX;
            end else begin
                n_out.verdict     = V_STARTED;
                wr_en             = 1'b1;
                set_vld           = 1'b1;
                wr_data.owner     = r_s1.owner_bit;
                wr_data.version   = r_s1.hdr_version;
                wr_data.next_seq  = 2'd1;
                wr_data.first_len = plen;
                wr_data.total_len = {9'd0, plen};
                wr_data.msg_type  = r_s1.msg_type;
            end
        end else if (!active) begin
            n_out.verdict = V_NO_CTX;
        end else if (ctx.version != r_s1.hdr_version) begin
            n_out.verdict = V_VER_DROP;
        end else if (ctx.next_seq != r_s1.packet_seq || ctx.owner != r_s1.owner_bit ||
                     ctx.first_len < plen) begin
            n_out.verdict = V_MISMATCH;
            clr_vld       = 1'b1;
        end else if (r_s1.end_mark) begin
            n_out.verdict       = V_ASSEMBLED;
            deliver             = 1'b1;
            n_out.consumer      = pick_consumer(ctx.msg_type, i_cfg);
            n_out.delivered_len = sum_sat;
            clr_vld             = 1'b1;
        end else if (ctx.first_len != plen) begin
            n_out.verdict = V_LEN_ABORT;
            clr_vld       = 1'b1;
        end else begin
            n_out.verdict     = V_APPENDED;
            wr_en             = 1'b1;
            wr_data.total_len = sum_sat;
            wr_data.next_seq  = ctx.next_seq + 2'd1;
        end
        if (deliver) begin
            n_out.receiver_out = r_s1.dest_eid;
            n_out.sender_out   = r_s1.source_eid;
            n_out.owner_out    = r_s1.owner_bit;
        end
        if (!s1_fire) begin
            wr_en   = 1'b0;
            set_vld = 1'b0;
            clr_vld = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_vld     <= '0;
            r_fwd     <= 1'b0;
        end else begin
            if (in_fire) begin
                r_s1_vld <= 1'b1;
            end else if (s1_fire) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_fire) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
            if (set_vld) begin
                r_vld[s1_idx] <= 1'b1;
            end else if (clr_vld) begin
                r_vld[s1_idx] <= 1'b0;
            end
            r_fwd <= wr_en && (s1_idx == rd_addr);
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1 <= in_pkt;
        end
        if (s1_fire) begin
            r_out <= n_out;
        end
        r_fwd_data <= wr_data;
    end

    // Result beat
    assign o_res.valid         = r_out_vld;
    assign o_res.verdict       = r_out.verdict;
    assign o_res.consumer      = r_out.consumer;
    assign o_res.delivered_len = r_out.delivered_len;
    assign o_res.receiver_out  = r_out.receiver_out;
    assign o_res.sender_out    = r_out.sender_out;
    assign o_res.tag_out       = r_out.tag_out;
    assign o_res.owner_out     = r_out.owner_out;

    // Checks
    `MPRT_ASSERT(a_start_sets_ctx, set_vld |=> r_vld[$past(s1_idx)], "start did not open context")
    `MPRT_ASSERT(a_abort_clears_ctx, clr_vld |=> !r_vld[$past(s1_idx)], "context not cleared")
    `MPRT_ASSERT(a_fwd_after_write, r_fwd |-> $past(wr_en), "forward without write")
    `MPRT_ASSERT_NEVER(a_no_len_without_delivery,
        r_out_vld && r_out.verdict != V_SINGLE && r_out.verdict != V_ASSEMBLED &&
        (r_out.delivered_len != 16'd0 || r_out.consumer != CONS_NONE),
        "length or consumer set without delivery")

endmodule
